// File: rtl/fgs_pkg.sv
// ----------------------------------------------------------------------------
// Fuzzy gain scheduler package
// Shared payload types, register indexes and a breakpoint helper function.
// ----------------------------------------------------------------------------
package fgs_pkg;

  localparam int unsigned NumBp     = 7;
  localparam int unsigned BpW       = 9;
  localparam int unsigned SegW      = 3;
  localparam int unsigned GainW     = 8;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned OutW      = 10;
  localparam int unsigned LastSeg   = 6;
  localparam int unsigned CfgAddrW  = 6;

  typedef enum logic [2:0] {
    RegErrBp    = 3'd0,
    RegSecBp    = 3'd1,
    RegGains    = 3'd2,
    RegRules02  = 3'd3,
    RegRules35  = 3'd4,
    RegRules6   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] error_sample;
    logic signed [SampleW-1:0] second_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [OutW-1:0] gain_out;
    logic [SegW-1:0]        error_segment;
    logic [SegW-1:0]        second_segment;
    logic [SegW-1:0]        rule_entry;
  } out_item_t;

  typedef struct packed {
    logic [62:0] err_bp;
    logic [62:0] sec_bp;
    logic [55:0] gains;
    logic [62:0] rules02;
    logic [62:0] rules35;
    logic [20:0] rules6;
  } cfg_t;

  function automatic logic signed [BpW-1:0] bp_at(input logic [62:0] p,
                                                  input logic [SegW-1:0] k);
    logic signed [BpW-1:0] r;
    r = '0;
    for (int i = 0; i < NumBp; i++) begin
      if (k == SegW'(i)) r = p[BpW*i +: BpW];
    end
    return r;
  endfunction

endpackage

// File: rtl/fuzzy_gain_scheduler.sv
// ----------------------------------------------------------------------------
// Fuzzy gain scheduler
// Schedules a gain from an error and a second signal over a 7x7 rule table.
// ----------------------------------------------------------------------------
// Usage: push a sample pair while full is low; results come out in order
// and are taken with pop while empty is low. One transfer per cycle is
// sustained in each direction while the receiver keeps popping. The
// segment search is registered at the accepting edge, followed by
// FRACTION_BITS+1 bit-per-stage divider stages, three for rule lookup,
// product and rounding, and one into the result head register. The
// pipeline never stalls; the result queue holds enough entries for every
// item in flight, and full is raised when queued plus in-flight items
// would overflow it, so a stalled receiver backs up to the input. After
// reset the queue is empty and all configuration registers read zero.
// The user must write configuration through the APB port only while the
// block is idle; the block itself does not enforce this.
module fuzzy_gain_scheduler #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  fgs_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output fgs_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import fgs_pkg::*;

  localparam int unsigned Depth = 32;
  localparam int unsigned AW    = $clog2(Depth);

  cfg_t cfg_q;
  logic [2:0] ridx;
  assign pready = 1'b1;
  assign ridx   = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        RegErrBp:   cfg_q.err_bp  <= pwdata[62:0];
        RegSecBp:   cfg_q.sec_bp  <= pwdata[62:0];
        RegGains:   cfg_q.gains   <= pwdata[55:0];
        RegRules02: cfg_q.rules02 <= pwdata[62:0];
        RegRules35: cfg_q.rules35 <= pwdata[62:0];
        RegRules6:  cfg_q.rules6  <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      RegErrBp:   prdata = 64'(cfg_q.err_bp);
      RegSecBp:   prdata = 64'(cfg_q.sec_bp);
      RegGains:   prdata = 64'(cfg_q.gains);
      RegRules02: prdata = 64'(cfg_q.rules02);
      RegRules35: prdata = 64'(cfg_q.rules35);
      RegRules6:  prdata = 64'(cfg_q.rules6);
      default:    prdata = '0;
    endcase
  end

  logic accept, fv;
  logic [2:0] se, ss;
  logic [9:0] ne, spe, ns, sps;
  assign accept = push && !full;

  fgs_front u_front (
    .clk_i, .rst_ni, .valid_i(accept), .item_i(in_item_i), .cfg_i(cfg_q),
    .valid_o(fv), .seg_e_o(se), .seg_s_o(ss), .num_e_o(ne), .span_e_o(spe),
    .num_s_o(ns), .span_s_o(sps));

  logic bv;
  out_item_t bitem;
  fgs_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni, .valid_i(fv), .seg_e_i(se), .seg_s_i(ss),
    .num_e_i(ne), .span_e_i(spe), .num_s_i(ns), .span_s_i(sps),
    .cfg_i(cfg_q), .valid_o(bv), .item_o(bitem));

  // Result queue with credit count covering items still in the pipeline.
  out_item_t        mem_q [Depth];
  out_item_t        head_q;
  logic             head_vld_q;
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q, cred_q;
  logic             deq, load, fetch, wr;

  assign empty = !head_vld_q;
  assign deq   = pop && !empty;
  assign full  = (cred_q >= (AW+1)'(Depth));
  assign out_item_o = head_q;

  // The head register refills from the memory, or straight from the pipeline
  // when the memory holds nothing.
  assign load  = !head_vld_q || deq;
  assign fetch = load && (cnt_q != '0);
  assign wr    = bv && !(load && (cnt_q == '0));

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= bitem;
    if (fetch) head_q <= mem_q[rp_q];
    else if (load && bv) head_q <= bitem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0; cred_q <= '0; head_vld_q <= 1'b0;
    end else begin
      if (wr) wp_q <= wp_q + AW'(1);
      if (fetch) rp_q <= rp_q + AW'(1);
      if (load) head_vld_q <= fetch || bv;
      cnt_q  <= cnt_q + (AW+1)'(wr) - (AW+1)'(fetch);
      cred_q <= cred_q + (AW+1)'(accept) - (AW+1)'(deq);
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr |-> cnt_q < (AW+1)'(Depth)) else $error("result queue overflow");
  a_credit_cover: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cred_q) else $error("queue count above credit");
  a_depth_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cred_q <= (AW+1)'(Depth)) else $error("credit overrun");
`endif
endmodule

// File: rtl/fgs_front.sv
// ----------------------------------------------------------------------------
// Fuzzy gain scheduler front end
// Places both samples among their breakpoints and forms numerator and span.
// ----------------------------------------------------------------------------
module fgs_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  fgs_pkg::in_item_t item_i,
  input  fgs_pkg::cfg_t    cfg_i,
  output logic             valid_o,
  output logic [2:0]       seg_e_o,
  output logic [2:0]       seg_s_o,
  output logic [9:0]       num_e_o,
  output logic [9:0]       span_e_o,
  output logic [9:0]       num_s_o,
  output logic [9:0]       span_s_o
);
  import fgs_pkg::*;

  typedef struct packed {
    logic [2:0] seg;
    logic [9:0] num;
    logic [9:0] span;
  } loc_t;

  // A zero numerator stands for a zero fraction; invalid spans are folded in.
  function automatic loc_t locate(input logic [62:0] p,
                                  input logic signed [SampleW-1:0] x);
    loc_t r;
    logic [2:0] k;
    logic found;
    logic signed [17:0] hi, lo, sp, nm;
    k = 3'(LastSeg);
    found = 1'b0;
    r = '0;
    for (int i = 0; i < NumBp; i++) begin
      if (!found && (18'(x) <= 18'(signed'(p[BpW*i +: BpW])))) begin
        k = 3'(i);
        found = 1'b1;
      end
    end
    r.seg = k;
    hi = 18'(bp_at(p, k));
    lo = 18'(bp_at(p, k - 3'd1));
    sp = hi - lo;
    nm = (k <= 3'd3) ? (hi - 18'(x)) : (18'(x) - lo);
    if (found && k != 3'd0 && sp > 0 && nm >= 0) begin
      r.num  = nm[9:0];
      r.span = sp[9:0];
    end else begin
      r.num  = '0;
      r.span = 10'd1;
    end
    return r;
  endfunction

  loc_t le, ls;
  assign le = locate(cfg_i.err_bp, item_i.error_sample);
  assign ls = locate(cfg_i.sec_bp, item_i.second_sample);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    seg_e_o  <= le.seg;
    seg_s_o  <= ls.seg;
    num_e_o  <= le.num;
    span_e_o <= le.span;
    num_s_o  <= ls.num;
    span_s_o <= ls.span;
  end
endmodule

// File: rtl/fgs_div.sv
// ----------------------------------------------------------------------------
// Fuzzy gain scheduler fraction divider
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module fgs_div #(
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned TagW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [9:0]             num_i,
  input  logic [9:0]             span_i,
  input  logic [TagW-1:0]        tag_i,
  output logic                   valid_o,
  output logic [FRACTION_BITS:0] quot_o,
  output logic [TagW-1:0]        tag_o
);
  localparam int unsigned Steps = FRACTION_BITS + 1;

  // Numerator never exceeds span, so the quotient fits in FRACTION_BITS+1 bits.
  logic                    vld_q  [Steps+1];
  logic [10:0]             rem_q  [Steps+1];
  logic [9:0]              den_q  [Steps+1];
  logic [FRACTION_BITS:0]  quo_q  [Steps+1];
  logic [TagW-1:0]         tag_q  [Steps+1];

  assign vld_q[0] = valid_i;
  assign rem_q[0] = {1'b0, num_i};
  assign den_q[0] = span_i;
  assign quo_q[0] = '0;
  assign tag_q[0] = tag_i;

  for (genvar s = 0; s < Steps; s++) begin : g_stage
    logic [11:0] trial;
    assign trial = (s == 0) ? {1'b0, rem_q[s]} : {rem_q[s], 1'b0};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+1] <= 1'b0;
      else vld_q[s+1] <= vld_q[s];
    end
    always_ff @(posedge clk_i) begin
      den_q[s+1] <= den_q[s];
      tag_q[s+1] <= tag_q[s];
      if (trial >= {2'b0, den_q[s]}) begin
        rem_q[s+1] <= 11'(trial - {2'b0, den_q[s]});
        quo_q[s+1] <= {quo_q[s][FRACTION_BITS-1:0], 1'b1};
      end else begin
        rem_q[s+1] <= trial[10:0];
        quo_q[s+1] <= {quo_q[s][FRACTION_BITS-1:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign quot_o  = quo_q[Steps];
  assign tag_o   = tag_q[Steps];
endmodule

// File: rtl/fgs_back.sv
// ----------------------------------------------------------------------------
// Fuzzy gain scheduler back end
// Divides both fractions, looks up the rule and interpolates the gain.
// ----------------------------------------------------------------------------
module fgs_back #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [2:0]         seg_e_i,
  input  logic [2:0]         seg_s_i,
  input  logic [9:0]         num_e_i,
  input  logic [9:0]         span_e_i,
  input  logic [9:0]         num_s_i,
  input  logic [9:0]         span_s_i,
  input  fgs_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output fgs_pkg::out_item_t item_o
);
  import fgs_pkg::*;

  localparam int unsigned QW = FRACTION_BITS + 1;
  localparam int unsigned PW = FRACTION_BITS + 11;

  logic            ve, vs;
  logic [QW-1:0]   qe, qs;
  logic [5:0]      te, ts;

  fgs_div #(.FRACTION_BITS(FRACTION_BITS), .TagW(6)) u_div_e (
    .clk_i, .rst_ni, .valid_i, .num_i(num_e_i), .span_i(span_e_i),
    .tag_i({seg_e_i, seg_s_i}), .valid_o(ve), .quot_o(qe), .tag_o(te));
  fgs_div #(.FRACTION_BITS(FRACTION_BITS), .TagW(6)) u_div_s (
    .clk_i, .rst_ni, .valid_i, .num_i(num_s_i), .span_i(span_s_i),
    .tag_i({seg_s_i, seg_e_i}), .valid_o(vs), .quot_o(qs), .tag_o(ts));

  // Rule lookup and gain selection.
  logic [2:0] pe, ps, n;
  logic [5:0] pos;
  logic [2:0] raw;
  always_comb begin
    pe = te[5:3];
    ps = te[2:0];
    if (pe < 3'd3) begin
      pos = 6'(7 * pe + ps);
      raw = cfg_i.rules02[3*pos +: 3];
    end else if (pe < 3'd6) begin
      pos = 6'(7 * (pe - 3'd3) + ps);
      raw = cfg_i.rules35[3*pos +: 3];
    end else begin
      pos = 6'(ps);
      raw = cfg_i.rules6[3*ps +: 3];
    end
    n = (raw == 3'd7) ? 3'(LastSeg) : raw;
  end

  logic                  v1_q;
  logic signed [QW:0]    df_q;
  logic signed [8:0]     g0_q, dg_q;
  logic [8:0]            segs1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= ve;
  end
  always_ff @(posedge clk_i) begin
    df_q    <= signed'({1'b0, qe}) - signed'({1'b0, qs});
    g0_q    <= (n == 3'(LastSeg)) ? signed'({1'b0, cfg_i.gains[8*LastSeg +: 8]})
                                   : signed'({1'b0, cfg_i.gains[8*n +: 8]});
    dg_q    <= (n == 3'(LastSeg)) ? '0
               : signed'({1'b0, cfg_i.gains[8*(n+3'd1) +: 8]})
                 - signed'({1'b0, cfg_i.gains[8*n +: 8]});
    segs1_q <= {pe, ps, n};
  end

  // Product stage, then sign-magnitude truncation toward zero.
  logic                  v2_q;
  logic signed [PW-1:0]  tot_q;
  logic [8:0]            segs2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end
  always_ff @(posedge clk_i) begin
    tot_q   <= (PW'(g0_q) <<< FRACTION_BITS) + PW'(dg_q) * PW'(df_q);
    segs2_q <= segs1_q;
  end

  logic [PW-1:0] mag, sh;
  always_comb begin
    mag = tot_q[PW-1] ? PW'(-tot_q) : PW'(tot_q);
    sh  = mag >> FRACTION_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_o <= 1'b0;
    else valid_o <= v2_q;
  end
  always_ff @(posedge clk_i) begin
    item_o.gain_out       <= tot_q[PW-1] ? OutW'(-sh) : OutW'(sh);
    item_o.error_segment  <= segs2_q[8:6];
    item_o.second_segment <= segs2_q[5:3];
    item_o.rule_entry     <= segs2_q[2:0];
  end

`ifndef ASSERT_OFF
  a_lanes_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ve == vs) else $error("divider lanes out of step");
  a_tags_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ve |-> (te[5:3] == ts[2:0] && te[2:0] == ts[5:3]))
    else $error("divider tags disagree");
  a_entry_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> item_o.rule_entry != 3'd7) else $error("rule entry out of range");
`endif
endmodule
